@@ src/cartridge_bank_mapper_unit_defines.svh @@
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_UNIT_DEFINES_SVH
// Property that holds while out of reset.
`define CBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked also during reset.
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ src/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;
    localparam int MAX_PRG_BANKS_DEF = 32;
    localparam int MAX_CHR_BANKS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_FIXED  = 2'd0,
        KIND_SERIAL = 2'd1,
        KIND_SELECT = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_PRG   = 2'd1,
        FUNC_CHR   = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_KIND  = 2'd0,
        CFG_PRG   = 2'd1,
        CFG_CHR   = 2'd2,
        CFG_MIRR  = 2'd3
    } t_cfg_idx;

    // Classified word passed from front to back: bank number to reduce,
    // modulus, and how to build the offset.
    typedef struct packed {
        logic        zero;     // offset is zero
        logic        direct;   // offset is the low bits only, no bank
        logic [7:0]  bank;     // raw bank number
        logic [8:0]  modulus;  // divisor, nonzero
        logic        fix_last; // bank is modulus-1 (no reduction)
        logic        fix_sec;  // bank is modulus-2
        logic [1:0]  shift;    // 0: 1KB, 1: 4KB, 2: 8KB, 3: 16KB units
        logic [13:0] low;      // address bits inside the window
    } t_job;

    typedef struct packed {
        logic [18:0] rom_offset;
        logic [1:0]  mirroring;
        logic        irq_enabled;
        logic [7:0]  irq_latch;
        logic        irq_reload_pending;
    } t_result;
endpackage

@@ src/cbm_fifo.sv @@
// Small two-entry queue of words.
module cbm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

@@ src/cbm_front.sv @@
// Front end: register state, write handling and address classification.
module cbm_front #(
    parameter int MAX_PRG_BANKS = cbm_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = cbm_pkg::MAX_CHR_BANKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [5:0]       i_cfg_data,
    input  logic             i_push,
    input  logic [1:0]       i_func,
    input  logic [15:0]      i_address,
    input  logic [7:0]       i_write_data,
    input  logic             i_q_full,
    output logic             o_q_push,
    output cbm_pkg::t_job    o_job,
    output cbm_pkg::t_result o_stat
);
    import cbm_pkg::*;

    logic [1:0] r_kind;
    logic [5:0] r_prg_cnt, r_chr_cnt;
    logic [4:0] r_shift, r_ctrl, r_chr_lo, r_chr_hi, r_prg;
    logic [2:0] r_scnt;
    logic [7:0] r_sel;
    logic [7:0] r_bank [8];
    logic [7:0] r_irq_val;
    logic       r_irq_rel, r_irq_en;
    logic [1:0] r_mirr;

    logic [6:0] eff_prg, eff_chr;
    logic [4:0] sh_next, sv;
    logic       acc, wr, odd;
    logic [12:0] pa;
    logic [1:0] win;

    assign acc = i_push && !i_q_full;
    assign wr  = acc && (t_func'(i_func) == FUNC_WRITE) && i_address[15];
    assign odd = i_address[0];
    assign sh_next = {i_write_data[0], r_shift[4:1]};
    assign sv = sh_next;
    assign o_q_push = acc;

    always_comb begin
        eff_prg = {1'b0, r_prg_cnt};
        if (r_prg_cnt == 6'd0) eff_prg = 7'd1;
        if ({1'b0, r_prg_cnt} > 7'(MAX_PRG_BANKS)) eff_prg = 7'(MAX_PRG_BANKS);
        eff_chr = {1'b0, r_chr_cnt};
        if ({1'b0, r_chr_cnt} > 7'(MAX_CHR_BANKS)) eff_chr = 7'(MAX_CHR_BANKS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 2'd0; r_prg_cnt <= 6'd2; r_chr_cnt <= 6'd1;
            r_shift <= 5'h10; r_scnt <= 3'd0; r_ctrl <= 5'h1C;
            r_chr_lo <= 5'd0; r_chr_hi <= 5'd0; r_prg <= 5'd0;
            r_sel <= 8'd0; r_irq_val <= 8'd0; r_irq_rel <= 1'b0;
            r_irq_en <= 1'b0; r_mirr <= 2'd3;
            for (int k = 0; k < 8; k++) r_bank[k] <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_KIND: r_kind <= i_cfg_data[1:0];
                    CFG_PRG:  r_prg_cnt <= i_cfg_data;
                    CFG_CHR:  r_chr_cnt <= i_cfg_data;
                    CFG_MIRR: r_mirr <= i_cfg_data[0] ? 2'd2 : 2'd3;
                    default: ;
                endcase
            end
            if (wr && t_kind'(r_kind) == KIND_SERIAL) begin
                if (i_write_data[7]) begin
                    r_shift <= 5'h10; r_scnt <= 3'd0;
                    r_ctrl <= r_ctrl | 5'h0C;
                end else if (r_scnt < 3'd4) begin
                    r_shift <= sh_next; r_scnt <= r_scnt + 3'd1;
                end else begin
                    r_shift <= 5'h10; r_scnt <= 3'd0;
                    priority if (i_address <= 16'h9FFF) begin
                        r_ctrl <= sv; r_mirr <= sv[1:0];
                    end else if (i_address <= 16'hBFFF) begin
                        r_chr_lo <= sv;
                    end else if (i_address <= 16'hDFFF) begin
                        r_chr_hi <= sv;
                    end else begin
                        r_prg <= sv; r_mirr <= r_ctrl[1:0];
                    end
                end
            end
            if (wr && t_kind'(r_kind) == KIND_SELECT) begin
                priority if (i_address <= 16'h9FFF) begin
                    if (odd) r_bank[r_sel[2:0]] <= i_write_data;
                    else     r_sel <= i_write_data;
                end else if (i_address <= 16'hBFFF) begin
                    if (!odd) r_mirr <= i_write_data[0] ? 2'd3 : 2'd2;
                end else if (i_address <= 16'hDFFF) begin
                    if (odd) r_irq_rel <= 1'b1;
                    else     r_irq_val <= i_write_data;
                end else begin
                    r_irq_en <= odd;
                end
            end
        end
    end

    // Status after this word's write, as the result carries it.
    always_comb begin
        o_stat = '0;
        o_stat.mirroring = r_mirr;
        o_stat.irq_enabled = r_irq_en;
        o_stat.irq_latch = r_irq_val;
        o_stat.irq_reload_pending = r_irq_rel;
        if (wr && t_kind'(r_kind) == KIND_SELECT) begin
            priority if (i_address <= 16'h9FFF) begin
            end else if (i_address <= 16'hBFFF) begin
                if (!odd) o_stat.mirroring = i_write_data[0] ? 2'd3 : 2'd2;
            end else if (i_address <= 16'hDFFF) begin
                if (odd) o_stat.irq_reload_pending = 1'b1;
                else     o_stat.irq_latch = i_write_data;
            end else begin
                o_stat.irq_enabled = odd;
            end
        end
        if (wr && t_kind'(r_kind) == KIND_SERIAL && !i_write_data[7] && r_scnt >= 3'd4) begin
            if (i_address <= 16'h9FFF) o_stat.mirroring = sv[1:0];
            else if (i_address > 16'hDFFF) o_stat.mirroring = r_ctrl[1:0];
        end
    end

    // Classification.
    assign pa  = i_address[12:0];
    assign win = i_address[14:13];
    always_comb begin
        logic [12:0] ca;
        logic [1:0]  smode;
        o_job = '0;
        o_job.modulus = 9'd1;
        ca = pa;
        smode = r_ctrl[3:2];
        unique case (t_func'(i_func))
            FUNC_PRG: begin
                if (!i_address[15]) begin
                    o_job.zero = 1'b1;
                end else if (t_kind'(r_kind) == KIND_SELECT) begin
                    o_job.shift = 2'd2;
                    o_job.low = {1'b0, i_address[12:0]};
                    o_job.modulus = {1'b0, eff_prg, 1'b0};
                    unique case (win)
                        2'd0: if (r_sel[6]) o_job.fix_sec = 1'b1;
                              else o_job.bank = r_bank[6];
                        2'd1: o_job.bank = r_bank[7];
                        2'd2: if (r_sel[6]) o_job.bank = r_bank[6];
                              else o_job.fix_sec = 1'b1;
                        default: o_job.fix_last = 1'b1;
                    endcase
                end else begin
                    o_job.shift = 2'd3;
                    o_job.low = i_address[13:0];
                    o_job.modulus = {2'b0, eff_prg};
                    if (t_kind'(r_kind) == KIND_SERIAL) begin
                        if (smode <= 2'd1)
                            o_job.bank = {4'd0, r_prg[3:1], i_address[14]};
                        else if (smode == 2'd2)
                            o_job.bank = i_address[14] ? {4'd0, r_prg[3:0]} : 8'd0;
                        else if (i_address[14]) o_job.fix_last = 1'b1;
                        else o_job.bank = {4'd0, r_prg[3:0]};
                    end else if (i_address[14]) begin
                        o_job.fix_last = 1'b1;
                    end
                end
            end
            FUNC_CHR: begin
                o_job.low = {1'b0, pa};
                o_job.direct = 1'b1;
                if (eff_chr != 7'd0 && t_kind'(r_kind) == KIND_SERIAL) begin
                    o_job.direct = 1'b0;
                    if (!r_ctrl[4]) begin
                        o_job.shift = 2'd2;
                        o_job.bank = {4'd0, r_chr_lo[4:1]};
                        o_job.modulus = {2'b0, eff_chr};
                    end else begin
                        o_job.shift = 2'd1;
                        o_job.low = {2'b0, pa[11:0]};
                        o_job.bank = {3'd0, pa[12] ? r_chr_hi : r_chr_lo};
                        o_job.modulus = {1'b0, eff_chr, 1'b0};
                    end
                end else if (eff_chr != 7'd0 && t_kind'(r_kind) == KIND_SELECT) begin
                    o_job.direct = 1'b0;
                    o_job.shift = 2'd0;
                    o_job.modulus = {eff_chr, 2'b0} << 1;
                    ca = pa ^ {r_sel[7], 12'd0};
                    if (!ca[12]) begin
                        o_job.low = {3'd0, ca[10:0]};
                        o_job.bank = (ca[11] ? r_bank[1] : r_bank[0]) & 8'hFE;
                    end else begin
                        o_job.low = {4'd0, ca[9:0]};
                        o_job.bank = r_bank[3'd2 + {1'b0, ca[11:10]}];
                    end
                end
            end
            default: o_job.zero = 1'b1;
        endcase
    end
endmodule

@@ src/cbm_back.sv @@
// Back end: bank reduction by repeated subtraction and offset assembly.
module cbm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  cbm_pkg::t_job    i_job,
    input  cbm_pkg::t_result i_stat,
    output logic             o_q_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output cbm_pkg::t_result o_res
);
    import cbm_pkg::*;

    // Reduction: the bank is under 256 and the modulus at least 1, so a
    // restoring divider of 8 steps gives the remainder.
    logic       r_busy;
    logic [3:0] r_step;
    logic [8:0] r_rem;
    logic [7:0] r_num;
    t_job       r_job;
    t_result    r_stat;
    logic [8:0] trial;
    logic [8:0] bank;
    logic [18:0] off;

    assign trial = {r_rem[7:0], r_num[7]};
    assign o_q_pop = !r_busy && !i_q_empty;

    always_comb begin
        priority if (r_job.fix_last) bank = r_job.modulus - 9'd1;
        else if (r_job.fix_sec)      bank = r_job.modulus - 9'd2;
        else                         bank = r_rem;
        unique case (r_job.shift)
            2'd0: off = 19'({bank, 10'd0}) + 19'(r_job.low);
            2'd1: off = 19'({bank, 12'd0}) + 19'(r_job.low);
            2'd2: off = 19'({bank, 13'd0}) + 19'(r_job.low);
            default: off = 19'({bank, 14'd0}) + 19'(r_job.low);
        endcase
        if (r_job.direct) off = 19'(r_job.low);
        if (r_job.zero)   off = 19'd0;
    end

    assign o_out_push = r_busy && (r_step == 4'd8) && !i_out_full;
    always_comb begin
        o_res = r_stat;
        o_res.rom_offset = off;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job  <= i_job;
            r_stat <= i_stat;
            r_num  <= i_job.bank;
            r_rem  <= 9'd0;
        end else if (r_busy && r_step != 4'd8) begin
            r_num <= {r_num[6:0], 1'b0};
            r_rem <= (trial >= r_job.modulus) ? trial - r_job.modulus : trial;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 4'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_step <= 4'd0;
        end else if (r_busy) begin
            if (r_step != 4'd8) r_step <= r_step + 4'd1;
            else if (o_out_push) r_busy <= 1'b0;
        end
    end
endmodule

@@ src/cartridge_bank_mapper_unit.sv @@
// An accepted word is reduced by the 8-step restoring remainder unit, which
// takes the next word only after pushing its result into the output queue.
// Two-entry queues sit between front and back and at the output.
// Reset (synchronous, active low) restores all bank, IRQ and config state.
// Configuration takes effect at once; write only while idle.
// Top level of the cartridge bank mapper.
`include "cartridge_bank_mapper_unit_defines.svh"
module cartridge_bank_mapper_unit #(
    parameter int MAX_PRG_BANKS = cbm_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = cbm_pkg::MAX_CHR_BANKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [18:0] o_rom_offset,
    output logic [1:0]  o_mirroring,
    output logic        o_irq_enabled,
    output logic [7:0]  o_irq_latch,
    output logic        o_irq_reload_pending
);
    import cbm_pkg::*;

    logic    q_push, q_full, q_pop, q_empty, out_push, out_full;
    t_job    f_job, q_job;
    t_result f_stat, q_stat, b_res, out_res;

    cbm_front #(.MAX_PRG_BANKS(MAX_PRG_BANKS), .MAX_CHR_BANKS(MAX_CHR_BANKS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push(push), .i_func, .i_address, .i_write_data,
        .i_q_full(q_full), .o_q_push(q_push), .o_job(f_job), .o_stat(f_stat)
    );

    cbm_fifo #(.WIDTH($bits(t_job) + $bits(t_result))) u_jobq (
        .i_clk, .i_rst_n, .i_push(q_push), .i_data({f_job, f_stat}),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_data({q_job, q_stat})
    );

    cbm_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(q_job), .i_stat(q_stat),
        .o_q_pop(q_pop), .i_out_full(out_full), .o_out_push(out_push), .o_res(b_res)
    );

    cbm_fifo #(.WIDTH($bits(t_result))) u_outq (
        .i_clk, .i_rst_n, .i_push(out_push), .i_data(b_res),
        .o_full(out_full), .i_pop(pop), .o_empty(empty), .o_data(out_res)
    );

    assign full = q_full;
    assign o_rom_offset = out_res.rom_offset;
    assign o_mirroring = out_res.mirroring;
    assign o_irq_enabled = out_res.irq_enabled;
    assign o_irq_latch = out_res.irq_latch;
    assign o_irq_reload_pending = out_res.irq_reload_pending;

    `CBM_ASSERT(a_no_push_full, i_clk, i_rst_n, q_full |-> !q_push, "push into full job queue")
    `CBM_ASSERT(a_out_ok, i_clk, i_rst_n, out_push |-> !out_full, "result lost at full output queue")
    `CBM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "output queue not empty after reset")
endmodule
